@@ rtl/epr_pkg.sv @@
// shared types and constants of the four-channel echo ranger
`default_nettype none

package epr_pkg;

    // register map: scale factors first, then limits
    localparam int REG_COUNT  = 8;
    localparam int LIMIT_BASE = 4;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // channel, scale and limit part of a queue entry (ticks come on top)
    localparam int ENTRY_FIXED_W = 2 + 16 + 16;

    localparam logic [15:0] SCALE_RESET [8] = '{
        16'd17826, 16'd16935, 16'd17337, 16'd9100, 16'd0, 16'd0, 16'd0, 16'd0
    };
    localparam logic [15:0] LIMIT_RESET [8] = '{
        16'd800, 16'd800, 16'd800, 16'd1920, 16'd0, 16'd0, 16'd0, 16'd0
    };

    typedef struct packed {
        logic [1:0]  channel_index;
        logic [15:0] capture_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_channel;
        logic [15:0] pulse_ticks;
        logic [15:0] measured_distance;
        logic        in_range;
        logic [15:0] held_distance;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/echo_pulse_ranger_4ch_unit.sv @@
// top level of the four-channel ultrasonic echo ranger
// usage:
//   item channel: capture events (channel_index, capture_value), one transfer
//   when item_valid is high and item_stall low; each channel alternates
//   between a rising and a falling edge event
//   result channel: one transfer per falling edge carrying pulse width,
//   scaled distance, in-range flag and the channel's held distance
//   rising edges and channels beyond NUM_CHANNELS produce no result
//   path: a taken falling edge is written into the queue, and the back end
//   registers the multiply and compare into the output register when it
//   pops the entry
//   throughput: one item per cycle while item_stall is low, set by the
//   single multiplier in the back end and same-time queue push and pop
//   stall: the output register holds while result_stall is high; the
//   two-entry queue absorbs work until it is full, then item_stall rises
//   reset: all channels await a rising edge, held distances are zero, scale
//   and limit registers take their default values
//   configuration: apb writes at byte address 4*i, scale_ch0..3 then
//   limit_ch0..3; user writes only with no transfer in flight, unenforced
`default_nettype none

module echo_pulse_ranger_4ch_unit #(
    parameter int NUM_CHANNELS = 4,
    parameter int TIMER_BITS   = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // capture events
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire epr_pkg::item_t               item,
    // results
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output epr_pkg::result_t                  result,
    // register port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [epr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [epr_pkg::DATA_W-1:0]   pwdata,
    output logic [epr_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ENTRY_W = epr_pkg::ENTRY_FIXED_W + TIMER_BITS;

    // configuration registers
    logic [15:0] scale_reg [NUM_CHANNELS];
    logic [15:0] limit_reg [NUM_CHANNELS];

    logic [2:0]      reg_idx;
    logic [1:0]      reg_ch;
    logic            reg_ch_ok;
    logic [CH_W-1:0] reg_sel;
    logic            reg_is_limit;
    logic            cfg_write;

    // front to back queue
    logic               item_take;
    logic               q_push;
    logic [ENTRY_W-1:0] q_push_data;
    logic               q_pop;
    logic               q_head_valid;
    logic [ENTRY_W-1:0] q_head_data;
    logic               q_full;

    assign pready       = 1'b1;
    assign reg_idx      = paddr[4:2];
    assign reg_ch       = reg_idx[1:0];
    assign reg_ch_ok    = 32'(reg_ch) < NUM_CHANNELS;
    assign reg_sel      = CH_W'(reg_ch);
    assign reg_is_limit = 32'(reg_idx) >= epr_pkg::LIMIT_BASE;
    assign cfg_write    = psel && penable && pwrite && pready;

    // register read-back, unimplemented channels read as zero
    always_comb
    begin
        prdata = '0;
        if (reg_ch_ok)
        begin
            prdata = reg_is_limit ? {16'd0, limit_reg[reg_sel]}
                                  : {16'd0, scale_reg[reg_sel]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                scale_reg[c] <= epr_pkg::SCALE_RESET[3'(c)];
                limit_reg[c] <= epr_pkg::LIMIT_RESET[3'(c)];
            end
        end
        else if (cfg_write && reg_ch_ok)
        begin
            if (reg_is_limit)
            begin
                limit_reg[reg_sel] <= pwdata[15:0];
            end
            else
            begin
                scale_reg[reg_sel] <= pwdata[15:0];
            end
        end
    end

    // stall whole items while the queue has no room
    assign item_stall = q_full;
    assign item_take  = item_valid && !item_stall;

    epr_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIMER_BITS   (TIMER_BITS),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (item_take),
        .item   (item),
        .scale  (scale_reg),
        .limit  (limit_reg),
        .push   (q_push),
        .entry  (q_push_data)
    );

    epr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .full       (q_full)
    );

    epr_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIMER_BITS   (TIMER_BITS),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .out_valid  (result_valid),
        .out_stall  (result_stall),
        .out_data   (result)
    );

endmodule

`default_nettype wire

@@ rtl/epr_front.sv @@
// front end: edge phase tracking, rise capture and pulse width per channel
`default_nettype none

module epr_front #(
    parameter int NUM_CHANNELS = 4,
    parameter int TIMER_BITS   = 16,
    parameter int ENTRY_W      = epr_pkg::ENTRY_FIXED_W + TIMER_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire epr_pkg::item_t       item,
    input  wire logic [15:0]          scale [NUM_CHANNELS],
    input  wire logic [15:0]          limit [NUM_CHANNELS],
    output logic                      push,
    output logic [ENTRY_W-1:0]        entry
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                  phase_reg [NUM_CHANNELS];
    logic [TIMER_BITS-1:0] rise_reg  [NUM_CHANNELS];

    logic                  ch_ok;
    logic [CH_W-1:0]       ch_sel;
    logic [TIMER_BITS-1:0] cap_t;
    logic [TIMER_BITS-1:0] ticks;

    assign ch_ok  = 32'(item.channel_index) < NUM_CHANNELS;
    assign ch_sel = CH_W'(item.channel_index);
    assign cap_t  = TIMER_BITS'(item.capture_value);
    assign ticks  = cap_t - rise_reg[ch_sel];

    // falling edge of a known channel goes to the queue
    assign push  = accept && ch_ok && phase_reg[ch_sel];
    assign entry = {item.channel_index, scale[ch_sel], limit[ch_sel], ticks};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                phase_reg[c] <= 1'b0;
            end
        end
        else if (accept && ch_ok)
        begin
            phase_reg[ch_sel] <= !phase_reg[ch_sel];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ch_ok && !phase_reg[ch_sel])
        begin
            rise_reg[ch_sel] <= cap_t;
        end
    end

endmodule

`default_nettype wire

@@ rtl/epr_queue.sv @@
// two-entry queue between front and back end
`default_nettype none

module epr_queue #(
    parameter int WIDTH = 50
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data,
    output logic                  full
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign head_valid = count_reg != 2'd0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign full       = count_reg == 2'd2;

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && head_valid))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop && head_valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/epr_back.sv @@
// back end: scaling, limit check, held distance and output register
`default_nettype none

module epr_back #(
    parameter int NUM_CHANNELS = 4,
    parameter int TIMER_BITS   = 16,
    parameter int ENTRY_W      = epr_pkg::ENTRY_FIXED_W + TIMER_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire logic [ENTRY_W-1:0] head_data,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output epr_pkg::result_t        out_data
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PROD_W = TIMER_BITS + 16;

    logic [1:0]            e_ch;
    logic [15:0]           e_scale;
    logic [15:0]           e_limit;
    logic [TIMER_BITS-1:0] e_ticks;
    logic [CH_W-1:0]       ch_sel;
    logic [PROD_W-1:0]     product;
    logic [PROD_W-1:0]     dist_full;
    logic [15:0]           dist_sat;
    logic                  ok;

    logic [15:0]           held_reg [NUM_CHANNELS];
    logic                  valid_reg;
    epr_pkg::result_t      data_reg;

    assign {e_ch, e_scale, e_limit, e_ticks} = head_data;
    assign ch_sel    = CH_W'(e_ch);
    assign product   = PROD_W'(e_ticks) * PROD_W'(e_scale);
    assign dist_full = product >> 16;
    // saturate to 16 bits
    assign dist_sat  = (dist_full > PROD_W'(16'hFFFF)) ? 16'hFFFF : dist_full[15:0];
    assign ok        = dist_sat < e_limit;

    assign pop       = head_valid && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                held_reg[c] <= 16'd0;
            end
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
                if (ok)
                begin
                    held_reg[ch_sel] <= dist_sat;
                end
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg.result_channel    <= e_ch;
            data_reg.pulse_ticks       <= 16'(e_ticks);
            data_reg.measured_distance <= dist_sat;
            data_reg.in_range          <= ok;
            data_reg.held_distance     <= ok ? dist_sat : held_reg[ch_sel];
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_echo_pulse_ranger_4ch_unit.sv @@
// self-checking bench for the four-channel echo ranger: capture stimulus, ranging scoreboard
module tb_echo_pulse_ranger_4ch_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import epr_pkg::*;

    // ranging scoreboard: mirrors the per-channel edge tracking and holds the
    // ranging results still owed by the block, oldest first
    class range_tracker;
        logic [15:0] scale_q [4];
        logic [15:0] limit_q [4];
        bit          awaiting_fall [4];
        logic [15:0] rise_at [4];
        logic [15:0] held_at [4];
        result_t     pending_ranges [$];
        int unsigned mismatches;
        int unsigned captures;
        int unsigned results;
        int unsigned hits;

        function new();
            for (int c = 0; c < 4; c++)
            begin
                scale_q[c]       = SCALE_RESET[c];
                limit_q[c]       = LIMIT_RESET[c];
                awaiting_fall[c] = 1'b0;
                rise_at[c]       = '0;
                held_at[c]       = '0;
            end
            mismatches = 0;
            captures   = 0;
            results    = 0;
            hits       = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void set_register(int idx, logic [15:0] value);
            if (idx < LIMIT_BASE)
                scale_q[idx] = value;
            else
                limit_q[idx - LIMIT_BASE] = value;
        endfunction

        function void check_register(int idx, logic [15:0] got);
            logic [15:0] want;
            want = (idx < LIMIT_BASE) ? scale_q[idx] : limit_q[idx - LIMIT_BASE];
            if (got !== want)
                flag($sformatf("register %0d read back %0d, expected %0d", idx, got, want));
        endfunction

        // rising edge stores the capture, falling edge owes one ranging result
        function void note_capture(item_t ev);
            int unsigned ch;
            logic [15:0] ticks;
            logic [31:0] product;
            result_t     want;
            ch = ev.channel_index;
            captures++;
            if (!awaiting_fall[ch])
            begin
                rise_at[ch]       = ev.capture_value;
                awaiting_fall[ch] = 1'b1;
                return;
            end
            awaiting_fall[ch] = 1'b0;
            ticks   = ev.capture_value - rise_at[ch];
            product = ticks * scale_q[ch];
            want.result_channel    = ch[1:0];
            want.pulse_ticks       = ticks;
            want.measured_distance = product[31:16];
            want.in_range          = (product[31:16] < limit_q[ch]);
            if (want.in_range)
            begin
                held_at[ch] = product[31:16];
                hits++;
            end
            want.held_distance = held_at[ch];
            pending_ranges.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_ranges.size() == 0)
            begin
                flag($sformatf("unexpected result: ch %0d ticks %0d dist %0d ok %0d held %0d",
                    got.result_channel, got.pulse_ticks, got.measured_distance,
                    got.in_range, got.held_distance));
                return;
            end
            want = pending_ranges.pop_front();
            results++;
            if (got !== want)
                flag($sformatf({"ch %0d/%0d ticks %0d/%0d dist %0d/%0d ok %0d/%0d held %0d/%0d",
                    " (expected/actual)"},
                    want.result_channel, got.result_channel, want.pulse_ticks, got.pulse_ticks,
                    want.measured_distance, got.measured_distance, want.in_range, got.in_range,
                    want.held_distance, got.held_distance));
        endfunction

        function int unsigned pending();
            return pending_ranges.size();
        endfunction
    endclass

    // block ports
    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    item_t               item;
    logic                result_valid;
    logic                result_stall;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // bench control shared between the sender and the receiver
    range_tracker board;
    int           max_gap;
    int           hold_request;
    int           settings_used;
    logic [15:0]  next_scale [4];
    logic [15:0]  next_limit [4];

    echo_pulse_ranger_4ch_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #10ms;
        $display("timeout: %0d results still outstanding", board.pending());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int draw_gap();
        return $urandom_range(0, max_gap);
    endfunction

    function automatic item_t capture_of(int ch, int cap);
        item_t ev;
        ev.channel_index = ch[1:0];
        ev.capture_value = cap[15:0];
        return ev;
    endfunction

    // one capture transfer: drop item_valid when gap is nonzero, then hold the item until taken
    task automatic send_capture(input item_t ev, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= ev;
        do @(posedge clk); while (item_stall !== 1'b0);
        board.note_capture(ev);
    endtask

    // stop offering, let every owed result arrive, then allow for the pipeline
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input int idx, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        // upper data bits carry noise, the registers are 16 bits wide
        pwdata  <= {16'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        board.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_register(input int idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * 4);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        board.check_register(idx, prdata[15:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write all eight registers from next_scale / next_limit and read them back
    task automatic apply_settings();
        for (int r = 0; r < REG_COUNT; r++)
            write_register(r, (r < LIMIT_BASE) ? next_scale[r] : next_limit[r - LIMIT_BASE]);
        for (int r = 0; r < REG_COUNT; r++)
            read_register(r);
        settings_used++;
    endtask

    // random capture; falling edges favour widths around the channel's limit
    task automatic random_capture(input int gap);
        int unsigned ch;
        int unsigned width;
        int unsigned thr;
        logic [15:0] cap;
        ch = $urandom_range(0, 3);
        if (!board.awaiting_fall[ch])
            cap = 16'($urandom());
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    width = $urandom_range(0, 4000);
                3, 4, 5:
                begin
                    if (board.scale_q[ch] == 0)
                        thr = $urandom_range(3, 65532);
                    else
                        thr = {board.limit_q[ch], 16'h0000} / board.scale_q[ch];
                    if (thr > 65532)
                        thr = 65532;
                    if (thr < 3)
                        thr = 3;
                    width = thr - 3 + $urandom_range(0, 6);
                end
                6, 7:
                    width = $urandom_range(0, 65535);
                default:
                    width = ($urandom_range(0, 2) == 0) ? 0 :
                            (($urandom_range(0, 1) == 0) ? 1 : 65535);
            endcase
            cap = board.rise_at[ch] + 16'(width);
        end
        send_capture(capture_of(ch, cap), gap);
    endtask

    // result side: random stall ahead of each transfer, plus a long hold-off on request
    initial
    begin
        int held;
        int gap;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request > 0)
            begin
                held         = hold_request;
                hold_request = 0;
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (held - 1) @(negedge clk);
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            result_stall <= 1'b0;
            do @(posedge clk); while (result_valid !== 1'b1);
            board.check_result(result);
        end
    end

    // main sequence
    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        max_gap       = 18;
        hold_request  = 0;
        settings_used = 1;
        board         = new();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed at the reset settings, channels interleaved
        send_capture(capture_of(0, 100), draw_gap());
        send_capture(capture_of(1, 65535), draw_gap());
        send_capture(capture_of(2, 5000), draw_gap());
        send_capture(capture_of(3, 40000), draw_gap());
        // equal captures give zero width
        send_capture(capture_of(0, 100), draw_gap());
        // timer wrap from the top value to zero gives one tick
        send_capture(capture_of(1, 0), draw_gap());
        // in range on channel 2
        send_capture(capture_of(2, 7000), draw_gap());
        // far beyond the limit on channel 3
        send_capture(capture_of(3, 34464), draw_gap());
        send_capture(capture_of(0, 65000), draw_gap());
        send_capture(capture_of(1, 0), draw_gap());
        send_capture(capture_of(2, 12345), draw_gap());
        send_capture(capture_of(3, 16'hAAAA), draw_gap());
        // just inside and just outside the limit, widest possible pulse, bit patterns
        send_capture(capture_of(0, 2364), draw_gap());
        send_capture(capture_of(1, 3100), draw_gap());
        send_capture(capture_of(2, 12344), draw_gap());
        send_capture(capture_of(3, 16'h5555), draw_gap());
        settle();

        // largest scale and limit everywhere
        for (int c = 0; c < 4; c++)
        begin
            next_scale[c] = 16'hFFFF;
            next_limit[c] = 16'hFFFF;
        end
        apply_settings();
        send_capture(capture_of(0, 0), draw_gap());
        send_capture(capture_of(0, 65535), draw_gap());
        send_capture(capture_of(1, 1), draw_gap());
        send_capture(capture_of(1, 0), draw_gap());
        settle();

        // zero scale with top limit on 0/1, top scale with zero limit on 2/3
        next_scale = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
        next_limit = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
        apply_settings();
        send_capture(capture_of(0, 300), draw_gap());
        send_capture(capture_of(0, 60000), draw_gap());
        send_capture(capture_of(2, 0), draw_gap());
        send_capture(capture_of(2, 65535), draw_gap());
        settle();

        // random phases, each under fresh register settings
        for (int k = 0; k < 6; k++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                case (k % 3)
                    0:
                    begin
                        next_scale[c] = 16'($urandom_range(8000, 20000));
                        next_limit[c] = 16'($urandom_range(200, 3000));
                    end
                    1:
                    begin
                        next_scale[c] = 16'($urandom());
                        next_limit[c] = 16'($urandom());
                    end
                    default:
                    begin
                        // extremes mixed with ordinary values
                        case ($urandom_range(0, 2))
                            0: next_scale[c] = 16'h0000;
                            1: next_scale[c] = 16'hFFFF;
                            default: next_scale[c] = 16'($urandom());
                        endcase
                        case ($urandom_range(0, 2))
                            0: next_limit[c] = 16'h0000;
                            1: next_limit[c] = 16'hFFFF;
                            default: next_limit[c] = 16'($urandom_range(0, 4000));
                        endcase
                    end
                endcase
            end
            apply_settings();
            // two phases run their transfers back to back with no idling on either side
            max_gap = (k == 2 || k == 5) ? 0 : 18;
            for (int j = 0; j < 140; j++)
            begin
                // long receiver hold-off while the sender keeps offering, queue fills up
                if (k == 1 && j == 40)
                    hold_request = 200;
                // sender pauses until everything owed has come out
                if (k == 3 && j == 70)
                    settle();
                random_capture((k == 1 && j >= 40 && j < 70) ? 0 : draw_gap());
            end
            settle();
        end
        max_gap = 18;

        $display("covered %0d capture transfers, %0d ranging results (%0d in range)",
            board.captures, board.results, board.hits);
        $display("under %0d register settings; %0d mismatches, %0d results outstanding",
            settings_used, board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
rtl/epr_pkg.sv
rtl/epr_front.sv
rtl/epr_queue.sv
rtl/epr_back.sv
rtl/echo_pulse_ranger_4ch_unit.sv
bench/tb_echo_pulse_ranger_4ch_unit.sv
